/* hw/rtl/timed_watering_relay_controller_defines.svh */
// ----------------------------------------------------------------------------
// Timed watering relay controller assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_WATERING_RELAY_CONTROLLER_DEFINES_SVH
`define TIMED_WATERING_RELAY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWRC_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWRC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* hw/rtl/twrc_pkg.sv */
// ----------------------------------------------------------------------------
// twrc_pkg
// Types and constants shared by the timed watering relay controller.
// ----------------------------------------------------------------------------
package twrc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned HTIME_W = 15;
    localparam int unsigned MOIST_W = 7;
    localparam int unsigned STAT_W  = 2;

    localparam logic [TIME_W-1:0]  RESYNC_MS   = 32'd30000;
    localparam logic [TIME_W-1:0]  OVERRUN_MS  = 32'd500;
    localparam logic [TIME_W-1:0]  RESTART_MS  = 32'd2000;
    localparam logic [MOIST_W-1:0] MOIST_LIMIT = 7'd90;
    localparam logic [HTIME_W-1:0] HTIME_RESET = 15'd5000;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_LOCKED   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FINISHED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RUNNING  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_TICK     = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [TIME_W-1:0]  now_ms;
        logic               sensor_present;
        logic               sensor_disconnected;
        logic               sensor_error;
        logic               sensor_stabilized;
        logic [MOIST_W-1:0] moisture_percent;
    } item_t;

    typedef struct packed {
        logic              relay_on;
        logic [STAT_W-1:0] status;
        logic              locked;
    } result_t;

endpackage

/* hw/rtl/twrc_in_stage.sv */
// ----------------------------------------------------------------------------
// twrc_in_stage
// Input register: captures one beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module twrc_in_stage
    import twrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t item_in,
    input  logic  advance,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // A held beat blocks new input only while the core cannot consume it.
    assign in_stall   = valid_reg && !advance;
    assign load       = !in_stall;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

/* hw/rtl/twrc_core.sv */
// ----------------------------------------------------------------------------
// twrc_core
// Controller state and the single-pass update for one tick or request.
// ----------------------------------------------------------------------------
module twrc_core
    import twrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  item_t              item,
    input  logic [HTIME_W-1:0] htime,
    output result_t            result
);

    logic              hydrating_reg, hydrating_next;
    logic              requested_reg, requested_next;
    logic              lock_reg, lock_next;
    logic              relay_reg, relay_next;
    logic [TIME_W-1:0] start_reg, start_next;

    logic              err;
    logic              disc;
    logic [TIME_W-1:0] t_ext;
    logic [TIME_W-1:0] diff0;
    logic              resync;
    logic [TIME_W-1:0] diff1;
    logic [TIME_W-1:0] start1;
    logic              restart;
    logic [TIME_W-1:0] elapsed;
    logic [STAT_W-1:0] status;

    assign err   = item.sensor_present && item.sensor_error;
    assign disc  = item.sensor_present && item.sensor_disconnected;
    assign t_ext = {{(TIME_W-HTIME_W){1'b0}}, htime};

    // Elapsed time after the long-idle resync and after the restart resync.
    assign diff0   = item.now_ms - start_reg;
    assign resync  = diff0 > RESYNC_MS;
    assign diff1   = resync ? '0 : diff0;
    assign start1  = resync ? item.now_ms : start_reg;
    assign restart = diff1 > (t_ext + RESTART_MS);
    assign elapsed = restart ? '0 : diff1;

    always_comb
    begin
        hydrating_next = hydrating_reg;
        requested_next = requested_reg;
        lock_next      = lock_reg;
        relay_next     = relay_reg;
        start_next     = start_reg;
        status         = STATUS_TICK;
        if (item.opcode == OP_REQUEST)
        begin
            if (lock_reg || err)
            begin
                relay_next = 1'b0;
                status     = STATUS_LOCKED;
            end
            else if (requested_reg && !hydrating_reg)
            begin
                requested_next = 1'b0;
                status         = STATUS_FINISHED;
            end
            else
            begin
                requested_next = 1'b1;
                status         = STATUS_RUNNING;
            end
        end
        else
        begin
            if (lock_reg)
            begin
                relay_next = 1'b0;
            end
            else if (disc)
            begin
                relay_next = relay_reg;
            end
            else if (err)
            begin
                hydrating_next = 1'b0;
                requested_next = 1'b0;
                relay_next     = 1'b0;
            end
            else
            begin
                start_next = start1;
                if ((diff1 > (t_ext + OVERRUN_MS)) && hydrating_reg)
                begin
                    hydrating_next = 1'b0;
                    lock_next      = 1'b1;
                    relay_next     = 1'b0;
                end
                else if (requested_reg)
                begin
                    start_next = restart ? item.now_ms : start1;
                    if ((elapsed < t_ext) && !hydrating_reg)
                    begin
                        hydrating_next = 1'b1;
                        start_next     = item.now_ms;
                        if (item.sensor_present && item.sensor_stabilized)
                        begin
                            relay_next = item.moisture_percent < MOIST_LIMIT;
                        end
                        else
                        begin
                            relay_next = 1'b1;
                        end
                    end
                    else if ((elapsed > t_ext) && hydrating_reg)
                    begin
                        hydrating_next = 1'b0;
                        relay_next     = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hydrating_reg <= 1'b0;
            requested_reg <= 1'b0;
            lock_reg      <= 1'b0;
            relay_reg     <= 1'b0;
            start_reg     <= '0;
        end
        else if (enable)
        begin
            hydrating_reg <= hydrating_next;
            requested_reg <= requested_next;
            lock_reg      <= lock_next;
            relay_reg     <= relay_next;
            start_reg     <= start_next;
        end
    end

    assign result.relay_on = relay_next;
    assign result.status   = status;
    assign result.locked   = lock_next;

endmodule

/* hw/rtl/timed_watering_relay_controller.sv */
// Path: an accepted beat is captured by the input register and then by the
// result register, from which its result beat is taken when the output is
// not stalled.
// Throughput: one item per cycle while the output is not stalled; the whole
// update is one combinational pass through the 32-bit elapsed-time subtract and compares.
// Reset (rst_n low, asynchronous) clears all flags, the start timestamp and the
// relay, and loads a run length of 5000 ms.
// ----------------------------------------------------------------------------
// timed_watering_relay_controller
// Pump relay controller for timed watering runs with an overrun lock.
// ----------------------------------------------------------------------------
module timed_watering_relay_controller
    import twrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [HTIME_W-1:0] hydrate_time_ms,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               sensor_present,
    input  logic               sensor_disconnected,
    input  logic               sensor_error,
    input  logic               sensor_stabilized,
    input  logic [MOIST_W-1:0] moisture_percent,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               relay_on,
    output logic [STAT_W-1:0]  status,
    output logic               locked
);

    logic [HTIME_W-1:0] htime_reg;
    item_t              item_in;
    item_t              item;
    logic               item_valid;
    logic               advance;
    result_t            result;
    result_t            result_reg;
    logic               out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            htime_reg <= HTIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            htime_reg <= hydrate_time_ms;
        end
    end

    assign item_in.opcode              = opcode;
    assign item_in.now_ms              = now_ms;
    assign item_in.sensor_present      = sensor_present;
    assign item_in.sensor_disconnected = sensor_disconnected;
    assign item_in.sensor_error        = sensor_error;
    assign item_in.sensor_stabilized   = sensor_stabilized;
    assign item_in.moisture_percent    = moisture_percent;

    // The result register can take a new beat when empty or being drained.
    assign advance = !out_valid_reg || !out_stall;

    twrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    twrc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (item_valid && advance),
        .item   (item),
        .htime  (htime_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign relay_on  = result_reg.relay_on;
    assign status    = result_reg.status;
    assign locked    = result_reg.locked;

endmodule

/* hw/rtl/twrc_checker.sv */
// ----------------------------------------------------------------------------
// twrc_checker
// Port-level checks for the timed watering relay controller.
// ----------------------------------------------------------------------------
`include "timed_watering_relay_controller_defines.svh"

module twrc_checker
    import twrc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              relay_on,
    input logic [STAT_W-1:0] status,
    input logic              locked
);

    logic lock_seen_reg;
    logic lock_seen_next;

    // Remembers that a delivered beat has reported the overrun lock.
    assign lock_seen_next = lock_seen_reg || (out_valid && !out_stall && locked);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_seen_reg <= 1'b0;
        end
        else
        begin
            lock_seen_reg <= lock_seen_next;
        end
    end

    `TWRC_ASSERT_IMPLY(a_lock_sticky, clk, rst_n, out_valid && lock_seen_reg, locked, "lock cleared without reset")
    `TWRC_ASSERT_IMPLY(a_lock_relay_off, clk, rst_n, out_valid && locked, !relay_on, "relay on while locked")
    `TWRC_ASSERT_IMPLY(a_error_relay_off, clk, rst_n, out_valid && (status == STATUS_LOCKED), !relay_on, "relay on with error status")
    `TWRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(relay_on) && $stable(status) && $stable(locked), "stalled output beat changed")

endmodule

bind timed_watering_relay_controller twrc_checker u_twrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .relay_on  (relay_on),
    .status    (status),
    .locked    (locked)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed watering relay controller testbench
// Sends update ticks and run requests through the valid/stall input, predicts
// relay drive, status and lock for every beat, and checks each output beat
// in order. The run length register is changed between phases while the
// block is idle. Both sides idle in random bursts, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import twrc_pkg::*;

    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 125;
    localparam int PRESSURE_PHASE = 2;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 8;

    localparam int unsigned PHASE_IDLE_PCT [N_PHASES] = '{10, 30, 15, 0, 50, 8, 20, 5, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [HTIME_W-1:0] cfg_run_len = '0;

    logic    in_valid = 1'b0;
    logic    in_stall;
    item_t   drv_item = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    result_t seen;

    // Pending input beats, and the results they are predicted to produce.
    item_t   item_q [$];
    result_t relay_expect_q [$];

    // Predicted controller state.
    logic [HTIME_W-1:0] run_len_ms = HTIME_RESET;
    logic               pump_running = 1'b0;
    logic               run_armed = 1'b0;
    logic               overrun_lock = 1'b0;
    logic [TIME_W-1:0]  run_start_ms = '0;
    logic               relay_drive = 1'b0;

    // Stimulus bookkeeping.
    logic [TIME_W-1:0] tick_clock_ms = '0;
    logic [TIME_W-1:0] gap_budget = OVERRUN_MS;
    int unsigned       idle_pct = 0;
    int unsigned       phase_len [N_PHASES];
    int                hold_requests = 0;
    int                holds_started = 0;
    int                hold_left = 0;
    int                send_idle = 0;
    int                recv_idle = 0;
    bit                beat_taken = 1'b0;
    int                mismatches = 0;
    int                beats_checked = 0;
    int                locked_beats = 0;
    int                status_seen [4] = '{0, 0, 0, 0};

    always #1 clk = ~clk;

    timed_watering_relay_controller i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .hydrate_time_ms     (cfg_run_len),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (drv_item.opcode),
        .now_ms              (drv_item.now_ms),
        .sensor_present      (drv_item.sensor_present),
        .sensor_disconnected (drv_item.sensor_disconnected),
        .sensor_error        (drv_item.sensor_error),
        .sensor_stabilized   (drv_item.sensor_stabilized),
        .moisture_percent    (drv_item.moisture_percent),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .relay_on            (seen.relay_on),
        .status              (seen.status),
        .locked              (seen.locked)
    );

    function automatic result_t predict_relay(item_t it);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] elapsed;
        logic              disc;
        logic              err;
        result_t           r;
        span = TIME_W'(run_len_ms);
        disc = it.sensor_present & it.sensor_disconnected;
        err  = it.sensor_present & it.sensor_error;
        if (it.opcode == OP_REQUEST)
        begin
            if (overrun_lock || err)
            begin
                relay_drive = 1'b0;
                r.status = STATUS_LOCKED;
            end
            else if (run_armed && !pump_running)
            begin
                run_armed = 1'b0;
                r.status = STATUS_FINISHED;
            end
            else
            begin
                if (!run_armed && !pump_running)
                    run_armed = 1'b1;
                r.status = STATUS_RUNNING;
            end
        end
        else
        begin
            r.status = STATUS_TICK;
            // A disconnected sensor masks an error reported on the same tick.
            if (overrun_lock)
                relay_drive = 1'b0;
            else if (err && !disc)
            begin
                pump_running = 1'b0;
                run_armed = 1'b0;
                relay_drive = 1'b0;
            end
            else if (!disc)
            begin
                elapsed = it.now_ms - run_start_ms;
                if (elapsed > RESYNC_MS)
                    run_start_ms = it.now_ms;
                elapsed = it.now_ms - run_start_ms;
                if (elapsed > span + OVERRUN_MS && pump_running)
                begin
                    pump_running = 1'b0;
                    overrun_lock = 1'b1;
                    relay_drive = 1'b0;
                end
                else if (run_armed)
                begin
                    if (elapsed > span + RESTART_MS)
                        run_start_ms = it.now_ms;
                    elapsed = it.now_ms - run_start_ms;
                    if (elapsed < span && !pump_running)
                    begin
                        pump_running = 1'b1;
                        run_start_ms = it.now_ms;
                        if (it.sensor_present && it.sensor_stabilized)
                            relay_drive = (it.moisture_percent < MOIST_LIMIT);
                        else
                            relay_drive = 1'b1;
                    end
                    else if (elapsed > span && pump_running)
                    begin
                        pump_running = 1'b0;
                        relay_drive = 1'b0;
                    end
                end
            end
        end
        r.relay_on = relay_drive;
        r.locked = overrun_lock;
        return r;
    endfunction

    // Input side: predict at the accepting edge, present the next beat at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            relay_expect_q.push_back(predict_relay(drv_item));
            beat_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (send_idle != 0)
            begin
                send_idle--;
                in_valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_idle = $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                drv_item <= item_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side stall, including the long hold-off that backs the block up.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_started != hold_requests)
        begin
            holds_started++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (recv_idle != 0)
        begin
            recv_idle--;
            out_stall <= 1'b1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            recv_idle = $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (relay_expect_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: relay_on %0b status %0d locked %0b",
                         $time, seen.relay_on, seen.status, seen.locked);
                mismatches++;
            end
            else
            begin
                want = relay_expect_q.pop_front();
                if (seen.relay_on !== want.relay_on)
                begin
                    $display("%0t: relay_on expected %0b actual %0b",
                             $time, want.relay_on, seen.relay_on);
                    mismatches++;
                end
                if (seen.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, seen.status);
                    mismatches++;
                end
                if (seen.locked !== want.locked)
                begin
                    $display("%0t: locked expected %0b actual %0b",
                             $time, want.locked, seen.locked);
                    mismatches++;
                end
                beats_checked++;
                status_seen[want.status]++;
                if (want.locked)
                    locked_beats++;
            end
        end
    end

    task automatic push_item(logic op, logic [TIME_W-1:0] stamp, logic pres, logic disc,
                             logic err, logic stab, logic [MOIST_W-1:0] moist);
        item_t it;
        it.opcode = op;
        it.now_ms = stamp;
        it.sensor_present = pres;
        it.sensor_disconnected = disc;
        it.sensor_error = err;
        it.sensor_stabilized = stab;
        it.moisture_percent = moist;
        item_q.push_back(it);
    endtask

    // Tick time only moves in steps that let a running pump be stopped before the
    // overrun window closes, or in jumps far enough to force a resync. A present,
    // disconnected sensor hides ticks, so their steps count against one budget.
    task automatic push_random();
        item_t             it;
        logic              effective;
        logic [TIME_W-1:0] step;
        int unsigned       pick;
        it = '0;
        it.now_ms = $urandom();
        it.sensor_present = ($urandom_range(0, 99) < 75);
        it.sensor_disconnected = $urandom_range(0, 1);
        it.sensor_error = $urandom_range(0, 1);
        it.sensor_stabilized = $urandom_range(0, 1);
        it.moisture_percent = $urandom_range(0, 127);
        if ($urandom_range(0, 99) < 15)
        begin
            it.opcode = OP_REQUEST;
            if (it.sensor_present)
                it.sensor_error = ($urandom_range(0, 99) < 5);
        end
        else
        begin
            it.opcode = OP_TICK;
            if (it.sensor_present)
            begin
                it.sensor_disconnected = ($urandom_range(0, 99) < 5);
                it.sensor_error = ($urandom_range(0, 99) < 3);
                it.sensor_stabilized = ($urandom_range(0, 99) < 65);
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    it.moisture_percent = $urandom_range(85, 94);
                else if (pick < 38)
                    it.moisture_percent = $urandom_range(101, 127);
                else
                    it.moisture_percent = $urandom_range(0, 100);
            end
            effective = !(it.sensor_present && it.sensor_disconnected);
            if (effective && gap_budget == OVERRUN_MS && $urandom_range(0, 99) < 4)
                step = $urandom_range(30001, 32'hFFFF_FFFF);
            else
                step = $urandom_range(0, gap_budget);
            tick_clock_ms += step;
            it.now_ms = tick_clock_ms;
            if (effective)
                gap_budget = OVERRUN_MS;
            else
                gap_budget -= step;
        end
        item_q.push_back(it);
    endtask

    // Ends a phase with no run in progress, so a new run length cannot trip the lock.
    task automatic push_clearing_tick(logic [TIME_W-1:0] stamp);
        push_item(OP_TICK, stamp, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0);
        tick_clock_ms = stamp;
        gap_budget = OVERRUN_MS;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (item_q.size() != 0 || in_valid || relay_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_run_len(logic [HTIME_W-1:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_run_len <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        run_len_ms = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset run length of 5000 ms.
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 7'd100);
        // Sensor flags are ignored when no sensor is attached.
        push_item(OP_TICK, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 7'd127);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd400, 1'b1, 1'b0, 1'b0, 1'b1, 7'd50);
        push_item(OP_TICK, 32'd5000, 1'b1, 1'b1, 1'b0, 1'b1, 7'd50);
        push_item(OP_TICK, 32'd5000, 1'b1, 1'b0, 1'b0, 1'b1, 7'd50);
        push_item(OP_TICK, 32'd5001, 1'b1, 1'b0, 1'b0, 1'b1, 7'd50);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        // A finished run still armed restarts once the restart window has passed.
        push_item(OP_TICK, 32'd7002, 1'b1, 1'b0, 1'b0, 1'b1, 7'd90);
        push_item(OP_TICK, 32'd7003, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd7100, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd9103, 1'b1, 1'b0, 1'b0, 1'b1, 7'd89);
        push_item(OP_TICK, 32'd39104, 1'b1, 1'b0, 1'b0, 1'b1, 7'd127);
        // Time wraps through all ones back to a small value.
        push_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0);
        push_item(OP_TICK, 32'd5100, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0);
        push_item(OP_TICK, 32'd12101, 1'b1, 1'b0, 1'b0, 1'b1, 7'd127);
        push_clearing_tick(32'd12101);
        push_item(OP_REQUEST, $urandom(), 1'b1, 1'b0, 1'b0, 1'b1, 7'd0);

        phase_len = '{25000, 1, 700, 0, 12000, 0, 0, 3, 25000};
        phase_len[5] = $urandom_range(1, 25000);
        phase_len[6] = $urandom_range(1, 3000);
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            write_run_len(HTIME_W'(phase_len[ph]));
            idle_pct = PHASE_IDLE_PCT[ph];
            @(posedge clk);
            if (ph == PRESSURE_PHASE)
                hold_requests++;
            if (ph == 4)
                push_clearing_tick(32'hFFFF_8000);
            repeat (PHASE_ITEMS) push_random();
            push_clearing_tick($urandom());
        end

        // Drive a short run past its overrun window; the lock holds to the end.
        wait_idle();
        write_run_len(15'd100);
        push_clearing_tick(32'd1000);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd3101, 1'b1, 1'b0, 1'b0, 1'b1, 7'd20);
        push_item(OP_TICK, 32'd3801, 1'b1, 1'b0, 1'b0, 1'b1, 7'd20);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_REQUEST, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd43801, 1'b1, 1'b1, 1'b0, 1'b1, 7'd20);
        push_item(OP_TICK, 32'd43900, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        wait_idle();
        write_run_len(15'd25000);
        push_item(OP_REQUEST, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        push_item(OP_TICK, 32'd50000, 1'b1, 1'b0, 1'b0, 1'b1, 7'd10);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d result beats checked over %0d run-length settings, lock seen on %0d beats",
                 beats_checked, N_PHASES + 3, locked_beats);
        $display("status mix: locked/error %0d, finished %0d, running %0d, tick %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/twrc_pkg.sv
hw/rtl/twrc_in_stage.sv
hw/rtl/twrc_core.sv
hw/rtl/timed_watering_relay_controller.sv
hw/rtl/twrc_checker.sv
sim/tb_top.sv
